// ===== design/bvdt_pkg.sv =====
// Shared types and constants for the binary variable domain tracker.
// No dependencies; every other design file but the checker imports this package.
package bvdt_pkg;

   localparam logic [1:0] DOM_FREE = 2'd0;
   localparam logic [1:0] DOM_FIX0 = 2'd1;
   localparam logic [1:0] DOM_FIX1 = 2'd2;
   localparam logic [1:0] DOM_PROC = 2'd3;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam int FIELD_W = 9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // latch the request fields
      logic exec;     // decide and do unlinks plus first append half
      logic ap2;      // second append half
      logic start;    // apply the variable count, clear counters
      logic sweep;    // write one entry of the rebuild
      logic capture;  // load the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } ctrl_status_type;

   // Commands to one linked list.
   typedef struct packed {
      logic unl;
      logic ap1;
      logic ap2;
      logic sweep;
      logic start_chain;
      logic start_empty;
   } list_cmd_type;

   typedef struct packed {
      logic ap_fixed;
      logic ap_free;
      logic illegal;
   } dec_type;

endpackage

// ===== design/bvdt_list.sv =====
// One doubly linked list: prev and next link memories plus head and tail.
// Depends on bvdt_pkg.
module bvdt_list
   import bvdt_pkg::*;
#(
   parameter int MAX_VARS = 256
) (
   input  logic                              clock,
   input  list_cmd_type                      cmd,
   input  logic [$clog2(MAX_VARS)-1:0]       k_addr,
   input  logic [$clog2(MAX_VARS+2)-1:0]     k_link,
   input  logic [$clog2(MAX_VARS)-1:0]       sweep_idx,
   input  logic [$clog2(MAX_VARS+2)-1:0]     n_lw,
   output logic [$clog2(MAX_VARS+2)-1:0]     head
);

   localparam int IW = $clog2(MAX_VARS);
   localparam int LW = $clog2(MAX_VARS + 2);

   logic [LW-1:0] prev_mem [MAX_VARS];
   logic [LW-1:0] next_mem [MAX_VARS];

   logic [LW-1:0] pv_ff, nx_ff;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic          prev_we, next_we;
   logic [IW-1:0] prev_wa, next_wa;
   logic [LW-1:0] prev_wd, next_wd;
   logic [LW-1:0] s_lw, e_lw, i_lw;

   assign s_lw = n_lw;
   assign e_lw = n_lw + LW'(1);
   assign i_lw = LW'(sweep_idx);
   assign head = head_ff;

   always_comb begin
      prev_we = 1'b0;
      next_we = 1'b0;
      prev_wa = k_addr;
      next_wa = k_addr;
      prev_wd = '0;
      next_wd = '0;
      head_in = head_ff;
      tail_in = tail_ff;
      priority if (cmd.unl) begin
         if (pv_ff == s_lw) begin
            head_in = nx_ff;
         end else begin
            next_we = 1'b1;
            next_wa = pv_ff[IW-1:0];
            next_wd = nx_ff;
         end
         if (nx_ff == e_lw) begin
            tail_in = pv_ff;
         end else begin
            prev_we = 1'b1;
            prev_wa = nx_ff[IW-1:0];
            prev_wd = pv_ff;
         end
      end else if (cmd.ap1) begin
         prev_we = 1'b1;
         prev_wd = tail_ff;
         if (tail_ff == s_lw) begin
            head_in = k_link;
         end else begin
            next_we = 1'b1;
            next_wa = tail_ff[IW-1:0];
            next_wd = k_link;
         end
      end else if (cmd.ap2) begin
         next_we = 1'b1;
         next_wd = e_lw;
         tail_in = k_link;
      end else if (cmd.sweep) begin
         next_we = 1'b1;
         next_wa = sweep_idx;
         next_wd = (i_lw == n_lw - LW'(1)) ? e_lw : i_lw + LW'(1);
         prev_we = 1'b1;
         prev_wa = sweep_idx;
         prev_wd = (i_lw == '0) ? s_lw : i_lw - LW'(1);
         if (cmd.start_chain) begin
            head_in = '0;
            tail_in = n_lw - LW'(1);
         end
      end else if (cmd.start_empty) begin
         head_in = e_lw;
         tail_in = s_lw;
      end else begin
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      pv_ff   <= prev_mem[k_addr];
      nx_ff   <= next_mem[k_addr];
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== design/bvdt_datapath.sv =====
// Datapath: domain memory, the three lists, counters, count register, result.
// Depends on bvdt_pkg and bvdt_list.
module bvdt_datapath
   import bvdt_pkg::*;
#(
   parameter int MAX_VARS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  logic            csr_wen,
   input  logic [8:0]      csr_wdata,
   input  logic [7:0]      in_var_index,
   input  logic [1:0]      in_new_domain,
   output logic [FIELD_W-1:0] out_zero,
   output logic [FIELD_W-1:0] out_one,
   output logic               out_illegal,
   output logic [FIELD_W-1:0] out_free,
   output logic [FIELD_W-1:0] out_fixed,
   output logic [FIELD_W-1:0] out_unproc
);

   localparam int IW = $clog2(MAX_VARS);
   localparam int LW = $clog2(MAX_VARS + 2);
   localparam int CW = $clog2(MAX_VARS + 1);

   logic [8:0]    var_count_ff;
   logic [LW-1:0] n_ff, n_in;
   logic [CW-1:0] zero_ff, zero_in, one_ff, one_in;
   logic [7:0]    k_ff;
   logic [1:0]    dom_req_ff;
   logic [IW-1:0] idx_ff;
   dec_type       dec_ff, dec;
   logic [1:0]    dom_mem [MAX_VARS];
   logic [1:0]    cur_ff;
   logic          dom_we;
   logic [IW-1:0] dom_wa;
   logic [1:0]    dom_wd;
   logic [31:0]   k32, vc32, n32, cnt32_z, cnt32_o, h32_f, h32_x, h32_u;
   logic [IW-1:0] k_addr;
   logic [LW-1:0] k_link;
   logic [LW-1:0] head_free, head_fixed, head_unproc;
   list_cmd_type  c_fixed, c_free, c_unproc;
   logic          legal, in_range, first;
   logic          unl_fixed, unl_free, unl_unproc, ap_fixed, ap_free;

   assign k32    = 32'(k_ff);
   assign k_addr = k32[IW-1:0];
   assign k_link = k32[LW-1:0];
   assign first  = (idx_ff == '0);
   assign status.sweep_last = (LW'(idx_ff) == n_ff - LW'(1));

   // Count clamp applied on start.
   always_comb begin
      vc32 = 32'(var_count_ff);
      if (vc32 == 32'd0) n32 = 32'd1;
      else if (vc32 > 32'(MAX_VARS)) n32 = 32'(MAX_VARS);
      else n32 = vc32;
      n_in = n32[LW-1:0];
   end

   // Decision for a set request.
   always_comb begin
      in_range = (k32 < 32'(n_ff));
      legal = in_range && (cur_ff != dom_req_ff) && (cur_ff != DOM_PROC) &&
              !((cur_ff == DOM_FIX0) && (dom_req_ff == DOM_FIX1)) &&
              !((cur_ff == DOM_FIX1) && (dom_req_ff == DOM_FIX0));
      unl_fixed = 1'b0; unl_free = 1'b0; unl_unproc = 1'b0;
      ap_fixed = 1'b0; ap_free = 1'b0;
      zero_in = zero_ff;
      one_in = one_ff;
      if (legal) begin
         unique case (dom_req_ff)
            DOM_FIX0, DOM_FIX1: begin
               unl_free = 1'b1;
               ap_fixed = 1'b1;
               if (dom_req_ff == DOM_FIX1) one_in = one_ff + CW'(1);
               else zero_in = zero_ff + CW'(1);
            end
            DOM_FREE: begin
               unl_fixed = 1'b1;
               ap_free = 1'b1;
               if (cur_ff == DOM_FIX1) one_in = one_ff - CW'(1);
               else zero_in = zero_ff - CW'(1);
            end
            default: begin
               unl_unproc = 1'b1;
               if (cur_ff == DOM_FREE) begin
                  unl_free = 1'b1;
               end else begin
                  unl_fixed = 1'b1;
                  if (cur_ff == DOM_FIX1) one_in = one_ff - CW'(1);
                  else zero_in = zero_ff - CW'(1);
               end
            end
         endcase
      end
      dec.ap_fixed = ap_fixed;
      dec.ap_free  = ap_free;
      dec.illegal  = !legal && (!in_range || cur_ff != dom_req_ff);
   end

   always_comb begin
      c_fixed  = '0;
      c_free   = '0;
      c_unproc = '0;
      if (cmd.exec) begin
         c_fixed.unl  = unl_fixed;
         c_free.unl   = unl_free;
         c_unproc.unl = unl_unproc;
         c_fixed.ap1  = ap_fixed;
         c_free.ap1   = ap_free;
      end
      if (cmd.ap2) begin
         c_fixed.ap2 = dec_ff.ap_fixed;
         c_free.ap2  = dec_ff.ap_free;
      end
      if (cmd.sweep) begin
         c_free.sweep         = 1'b1;
         c_unproc.sweep       = 1'b1;
         c_free.start_chain   = first;
         c_unproc.start_chain = first;
         c_fixed.start_empty  = first;
      end
      dom_we = (cmd.exec && legal) || cmd.sweep;
      dom_wa = cmd.sweep ? idx_ff : k_addr;
      dom_wd = cmd.sweep ? DOM_FREE : dom_req_ff;
   end

   bvdt_list #(.MAX_VARS(MAX_VARS)) u_fixed (
      .clock, .cmd(c_fixed), .k_addr, .k_link, .sweep_idx(idx_ff), .n_lw(n_ff),
      .head(head_fixed));
   bvdt_list #(.MAX_VARS(MAX_VARS)) u_free (
      .clock, .cmd(c_free), .k_addr, .k_link, .sweep_idx(idx_ff), .n_lw(n_ff),
      .head(head_free));
   bvdt_list #(.MAX_VARS(MAX_VARS)) u_unproc (
      .clock, .cmd(c_unproc), .k_addr, .k_link, .sweep_idx(idx_ff), .n_lw(n_ff),
      .head(head_unproc));

   always_ff @(posedge clock) begin
      if (dom_we) dom_mem[dom_wa] <= dom_wd;
      cur_ff <= dom_mem[k_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff <= 9'd256;
         n_ff         <= '0;
         zero_ff      <= '0;
         one_ff       <= '0;
      end else begin
         if (csr_wen) var_count_ff <= csr_wdata;
         if (cmd.start) begin
            n_ff    <= n_in;
            zero_ff <= '0;
            one_ff  <= '0;
         end else if (cmd.exec) begin
            zero_ff <= zero_in;
            one_ff  <= one_in;
         end
      end
   end

   assign cnt32_z = 32'(zero_ff);
   assign cnt32_o = 32'(one_ff);
   assign h32_f   = 32'(head_free);
   assign h32_x   = 32'(head_fixed);
   assign h32_u   = 32'(head_unproc);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         k_ff       <= in_var_index;
         dom_req_ff <= in_new_domain;
      end
      if (cmd.start) idx_ff <= '0;
      else if (cmd.sweep) idx_ff <= idx_ff + IW'(1);
      if (cmd.start) dec_ff <= '0;
      else if (cmd.exec) dec_ff <= dec;
      if (cmd.capture) begin
         out_zero    <= cnt32_z[FIELD_W-1:0];
         out_one     <= cnt32_o[FIELD_W-1:0];
         out_illegal <= dec_ff.illegal;
         out_free    <= h32_f[FIELD_W-1:0];
         out_fixed   <= h32_x[FIELD_W-1:0];
         out_unproc  <= h32_u[FIELD_W-1:0];
      end
   end

endmodule

// ===== design/bvdt_ctrl.sv =====
// Controller state machine: sequences set and start commands, owns handshakes.
// Depends on bvdt_pkg.
module bvdt_ctrl
   import bvdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            req_op,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_AP2   = 3'd3;
   localparam logic [2:0] ST_START = 3'd4;
   localparam logic [2:0] ST_SWEEP = 3'd5;
   localparam logic [2:0] ST_CAPT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept, room;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) state_in = (req_op == OP_START) ? ST_START : ST_RD;
         end
         ST_RD:    state_in = ST_EXEC;
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_AP2;
         end
         ST_AP2: begin
            cmd.ap2  = 1'b1;
            state_in = ST_CAPT;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) state_in = ST_CAPT;
         end
         ST_CAPT: begin
            cmd.capture = room;
            if (room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = cmd.capture || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== design/binary_var_domain_tracker_unit.sv =====
// Top level of the binary variable domain tracker.
// Depends on bvdt_pkg, bvdt_ctrl and bvdt_datapath.
//
// This block keeps the domain of up to MAX_VARS binary variables (free, fixed
// to zero, fixed to one, processed) in three doubly linked lists held in
// link memories: fixed, free and unprocessed. A request beat with tuser high
// is a start: it applies the variable count written on the csr port (zero is
// taken as one, values above MAX_VARS as MAX_VARS), clears both counters and
// rebuilds every variable as free and unprocessed by sweeping the link
// memories one entry per cycle; the result is captured after the sweep and
// the next request can be taken once it is. A request beat with tuser low
// sets one variable's domain; it reads the domain and link memories, unlinks
// and appends in the shared single-write-port memories, then captures its
// result, and the next request is taken after that capture.
// A refused change (index out of range, a processed variable changed, or a
// direct swap between zero and one) returns illegal set and changes nothing.
// Until the first start every set is refused and the list heads in the
// result are meaningless. One result beat follows every request beat; the
// result register lets the next request be taken while a result waits.
module binary_var_domain_tracker_unit
   import bvdt_pkg::*;
#(
   parameter int MAX_VARS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits from lowest: var_index[7:0], new_domain[9:8], zero padding.
   input  logic [15:0] req_tdata,
   // Bits from lowest: op.
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits from lowest: count_fixed_zero[8:0], count_fixed_one[17:9],
   // illegal[18], first_free[27:19], first_fixed[36:28],
   // first_unprocessed[45:37], zero padding.
   output logic [47:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [8:0]  csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic [FIELD_W-1:0] r_zero, r_one, r_free, r_fixed, r_unproc;
   logic               r_illegal;

   // The controller sequences each request; the datapath holds all storage.
   bvdt_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser),
      .rsp_tvalid, .rsp_tready, .cmd, .status);

   bvdt_datapath #(.MAX_VARS(MAX_VARS)) u_dp (
      .clock, .reset, .cmd, .status, .csr_wen, .csr_wdata,
      .in_var_index(req_tdata[7:0]), .in_new_domain(req_tdata[9:8]),
      .out_zero(r_zero), .out_one(r_one), .out_illegal(r_illegal),
      .out_free(r_free), .out_fixed(r_fixed), .out_unproc(r_unproc));

   assign rsp_tdata = {2'b00, r_unproc, r_fixed, r_free, r_illegal, r_one, r_zero};

endmodule

// ===== design/bvdt_checker.sv =====
// Port-level checks for the domain tracker, bound to the top level.
// Depends on binary_var_domain_tracker_unit.
module bvdt_checker #(
   parameter int MAX_VARS = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   logic [9:0] fixed_sum;
   assign fixed_sum = {1'b0, rsp_tdata[8:0]} + {1'b0, rsp_tdata[17:9]};

   // One request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No more fixed variables than can exist.
   a_fixed_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (MAX_VARS > 511) || (fixed_sum <= 10'(MAX_VARS)))
      else $error("fixed counts exceed variable capacity");

   // Reset leaves no result pending and the request side open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind binary_var_domain_tracker_unit bvdt_checker #(.MAX_VARS(MAX_VARS)) u_bvdt_checker (.*);
